/* hw/rtl/stm_pkg.sv */
// Shared constants, codes and types for the scrolling text marquee.
// No dependencies; used by stm_scroll, stm_frame and the top level in hw/rtl.
package stm_pkg;

  localparam int DISPLAY_WIDTH = 32;
  localparam int TEXT_DEPTH    = 256;
  localparam int LOOP_GAP      = 3;

  localparam int ADDR_W = $clog2(TEXT_DEPTH);
  localparam int LEN_W  = $clog2(TEXT_DEPTH + 1);
  localparam int POS_W  = $clog2(TEXT_DEPTH + LOOP_GAP);
  // headroom for position + column and the differences taken from it
  localparam int SUM_W  = $clog2(TEXT_DEPTH + LOOP_GAP + DISPLAY_WIDTH) + 1;

  localparam int CHAR_W  = 8;
  localparam int COL_W   = 6;
  localparam int WID_W   = 7;
  localparam int CNT_W   = 16;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [CHAR_W-1:0] BLANK = 8'h20;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [1:0] MODE_LEFT  = 2'd0;
  localparam logic [1:0] MODE_RIGHT = 2'd1;
  localparam logic [1:0] MODE_LOOP  = 2'd2;

  localparam logic [1:0] ALIGN_LEFT   = 2'd0;
  localparam logic [1:0] ALIGN_CENTER = 2'd1;
  localparam logic [1:0] ALIGN_RIGHT  = 2'd2;

  localparam logic [2:0] REG_SCROLL_MODE     = 3'd0;
  localparam logic [2:0] REG_STEP_INTERVAL   = 3'd1;
  localparam logic [2:0] REG_HOLD_TICKS      = 3'd2;
  localparam logic [2:0] REG_REPEAT_ENABLE   = 3'd3;
  localparam logic [2:0] REG_ALIGNMENT       = 3'd4;
  localparam logic [2:0] REG_VISIBLE_COLUMNS = 3'd5;

  // settings as the datapath sees them; width already limited
  typedef struct packed {
    logic [1:0]       mode;
    logic [CNT_W-1:0] interval;
    logic [CNT_W-1:0] hold;
    logic             rpt;
    logic [1:0]       align;
    logic [WID_W-1:0] width;
  } cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] pos;
  } scroll_t;

  function automatic logic [WID_W-1:0] clamp_width(input logic [WID_W-1:0] v);
    logic [WID_W-1:0] r;
    r = v;
    if (v == '0) r = WID_W'(1);
    else if (v > WID_W'(DISPLAY_WIDTH)) r = WID_W'(DISPLAY_WIDTH);
    return r;
  endfunction

endpackage

/* hw/rtl/stm_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module stm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/stm_scroll.sv */
// Scroll state unit: text length, position, tick counter, hold and halt flags.
// Drives the text memory write port on appends. Depends on stm_pkg.
module stm_scroll (
  input  logic                          clk,
  input  logic                          rst,
  input  stm_pkg::cfg_t                 cfg,
  input  logic                          accept,
  input  logic                          operation,
  input  logic [stm_pkg::CHAR_W-1:0]    char_code,
  input  logic                          first_char,
  output logic                          we,
  output logic [stm_pkg::ADDR_W-1:0]    waddr,
  output logic [stm_pkg::CHAR_W-1:0]    wdata,
  output stm_pkg::scroll_t              st
);

  logic [stm_pkg::LEN_W-1:0] text_length, text_length_next, base, len_after;
  logic [stm_pkg::POS_W-1:0] pos, pos_next;
  logic [stm_pkg::CNT_W-1:0] cnt, cnt_next;
  logic                      holding, holding_next, halted, halted_next;

  logic [stm_pkg::SUM_W-1:0] len_x, w_x, pos_x, p_inc, span, period, new_len_x;
  logic [stm_pkg::CNT_W:0]   cnt_inc;
  logic                      hit_step, hit_hold;

  assign len_x    = stm_pkg::SUM_W'(text_length);
  assign w_x      = stm_pkg::SUM_W'(cfg.width);
  assign pos_x    = stm_pkg::SUM_W'(pos);
  assign p_inc    = pos_x + stm_pkg::SUM_W'(1);
  assign span     = len_x - w_x;
  assign period   = len_x + stm_pkg::SUM_W'(stm_pkg::LOOP_GAP);
  assign cnt_inc  = {1'b0, cnt} + (stm_pkg::CNT_W + 1)'(1);
  assign hit_step = cnt_inc >= {1'b0, cfg.interval};
  assign hit_hold = cnt_inc >= {1'b0, cfg.hold};

  assign base  = first_char ? '0 : text_length;
  assign waddr = base[stm_pkg::ADDR_W-1:0];
  assign wdata = char_code;
  assign we    = accept && (operation == stm_pkg::OP_APPEND) &&
                 (base < stm_pkg::LEN_W'(stm_pkg::TEXT_DEPTH));
  // length once this append has landed
  assign len_after = we ? base + stm_pkg::LEN_W'(1) : base;
  assign new_len_x = stm_pkg::SUM_W'(len_after);

  always_comb begin
    text_length_next = text_length;
    pos_next         = pos;
    cnt_next         = cnt;
    holding_next     = holding;
    halted_next      = halted;
    if (accept && operation == stm_pkg::OP_APPEND) begin
      text_length_next = len_after;
      pos_next         = '0;
      cnt_next         = '0;
      holding_next     = 1'b1;
      halted_next      = 1'b0;
      if (cfg.mode == stm_pkg::MODE_RIGHT && new_len_x > w_x) begin
        pos_next = stm_pkg::POS_W'(new_len_x - w_x);
      end
    end else if (accept && len_x > w_x) begin
      // short text leaves the scroll state alone
      if (cfg.mode == stm_pkg::MODE_LOOP) begin
        if (hit_step) begin
          cnt_next = '0;
          pos_next = (p_inc >= period) ? '0 : stm_pkg::POS_W'(p_inc);
        end else begin
          cnt_next = cnt_inc[stm_pkg::CNT_W-1:0];
        end
      end else if (!halted) begin
        if (holding) begin
          if (hit_hold) begin
            cnt_next     = '0;
            holding_next = 1'b0;
          end else begin
            cnt_next = cnt_inc[stm_pkg::CNT_W-1:0];
          end
        end else if (!hit_step) begin
          cnt_next = cnt_inc[stm_pkg::CNT_W-1:0];
        end else begin
          cnt_next = '0;
          if (cfg.mode == stm_pkg::MODE_LEFT) begin
            if (p_inc > span) begin
              if (cfg.rpt) begin
                pos_next     = '0;
                holding_next = 1'b1;
              end else begin
                pos_next    = stm_pkg::POS_W'(span);
                halted_next = 1'b1;
              end
            end else begin
              pos_next = stm_pkg::POS_W'(p_inc);
            end
          end else begin
            // right, and the unused mode code with it
            if (pos == '0) begin
              if (cfg.rpt) begin
                pos_next     = stm_pkg::POS_W'(span);
                holding_next = 1'b1;
              end else begin
                halted_next = 1'b1;
              end
            end else begin
              pos_next = pos - stm_pkg::POS_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_length <= '0;
      pos         <= '0;
      cnt         <= '0;
      holding     <= 1'b1;
      halted      <= 1'b0;
    end else begin
      text_length <= text_length_next;
      pos         <= pos_next;
      cnt         <= cnt_next;
      holding     <= holding_next;
      halted      <= halted_next;
    end
  end

  assign st.len = text_length;
  assign st.pos = pos;

endmodule

/* hw/rtl/stm_frame.sv */
// Frame sequencer: walks the columns, reads the text memory, holds the output word.
// Depends on stm_pkg; the memory itself sits in the top level.
module stm_frame (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  stm_pkg::cfg_t                 cfg,
  input  stm_pkg::scroll_t              st,
  output logic                          re,
  output logic [stm_pkg::ADDR_W-1:0]    raddr,
  input  logic [stm_pkg::CHAR_W-1:0]    rdata,
  output logic                          idle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [stm_pkg::COL_W-1:0]     column,
  output logic [stm_pkg::CHAR_W-1:0]    glyph,
  output logic                          last_column
);

  typedef enum logic [1:0] {IDLE, FETCH, LOAD, SEND} state_t;
  state_t state;

  logic [stm_pkg::COL_W-1:0] fcol, rcol;
  logic                      rblank;

  logic [stm_pkg::SUM_W-1:0] len_x, w_x, pos_x, c_x, gap, x, rel, sum, wrapped,
                             period, addr_x;
  logic                      short_text, blank, issue;

  assign len_x   = stm_pkg::SUM_W'(st.len);
  assign w_x     = stm_pkg::SUM_W'(cfg.width);
  assign pos_x   = stm_pkg::SUM_W'(st.pos);
  assign c_x     = stm_pkg::SUM_W'(fcol);
  assign period  = len_x + stm_pkg::SUM_W'(stm_pkg::LOOP_GAP);
  assign short_text = len_x <= w_x;
  assign gap     = w_x - len_x;

  always_comb begin
    case (cfg.align)
      stm_pkg::ALIGN_RIGHT:  x = gap;
      stm_pkg::ALIGN_CENTER: x = gap >> 1;
      default:               x = '0;
    endcase
  end

  assign rel     = c_x - x;
  assign sum     = pos_x + c_x;
  assign wrapped = (cfg.mode == stm_pkg::MODE_LOOP && sum >= period) ? sum - period : sum;

  always_comb begin
    if (short_text) begin
      addr_x = rel;
      blank  = !((c_x >= x) && (c_x < x + len_x));
    end else begin
      addr_x = wrapped;
      blank  = wrapped >= len_x;
    end
  end

  assign issue = (state == FETCH) || (state == SEND && out_ready && !last_column);
  assign re    = issue;
  assign raddr = addr_x[stm_pkg::ADDR_W-1:0];
  assign idle  = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            fcol  <= '0;
            state <= FETCH;
          end
        end
        FETCH: begin
          rcol   <= fcol;
          rblank <= blank;
          fcol   <= fcol + stm_pkg::COL_W'(1);
          state  <= LOAD;
        end
        LOAD: begin
          column      <= rcol;
          glyph       <= rblank ? stm_pkg::BLANK : rdata;
          last_column <= ({1'b0, rcol} == cfg.width - stm_pkg::WID_W'(1));
          out_valid   <= 1'b1;
          state       <= SEND;
        end
        SEND: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_column) begin
              state <= IDLE;
            end else begin
              rcol   <= fcol;
              rblank <= blank;
              fcol   <= fcol + stm_pkg::COL_W'(1);
              state  <= LOAD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/scrolling_text_marquee.sv */
// Top level of the scrolling text marquee: APB register file, text memory,
// scroll state unit and frame sequencer. Depends on stm_pkg, stm_ram,
// stm_scroll and stm_frame.
// Use: input words (operation, char_code, first_char) arrive on a valid/ready
// channel. An append word writes one byte to the text memory; first_char
// empties the text first. Bytes past the memory depth are dropped but still
// reset the scroll state. A tick word updates the scroll state in its accept
// cycle, then the frame sequencer emits one output word per visible column
// (column, glyph, last_column), last_column on the last.
// Order: for each column the memory read is issued first, then the output
// register is loaded from it. After a tick's accept the sequencer reads in
// FETCH, loads the output register in LOAD and offers the word in SEND; later
// reads are issued from SEND. in_ready stays low until the last column word is
// taken, so no new input word is accepted while a frame is in flight. The single
// text memory read port sets the pace. A stalled receiver simply holds the current
// output word; the next memory read is issued only in the cycle that word is taken.
// Reset (rst, synchronous): empty text, position zero, holding, not halted,
// registers at their defaults. The text memory itself is not cleared.
// Registers sit at byte addresses 4*i: mode, interval, hold, repeat,
// alignment, visible columns.
module scrolling_text_marquee (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stm_pkg::PADDR_W-1:0]   paddr,
  input  logic [stm_pkg::PDATA_W-1:0]   pwdata,
  output logic [stm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [stm_pkg::CHAR_W-1:0]    char_code,
  input  logic                          first_char,
  // output words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [stm_pkg::COL_W-1:0]     column,
  output logic [stm_pkg::CHAR_W-1:0]    glyph,
  output logic                          last_column
);

  // configuration registers
  logic [1:0]                scroll_mode;
  logic [stm_pkg::CNT_W-1:0] step_interval;
  logic [stm_pkg::CNT_W-1:0] hold_ticks;
  logic                      repeat_enable;
  logic [1:0]                alignment;
  logic [stm_pkg::WID_W-1:0] visible_columns;

  logic       cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[stm_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_mode     <= stm_pkg::MODE_LEFT;
      step_interval   <= stm_pkg::CNT_W'(1);
      hold_ticks      <= stm_pkg::CNT_W'(10);
      repeat_enable   <= 1'b1;
      alignment       <= stm_pkg::ALIGN_LEFT;
      visible_columns <= stm_pkg::WID_W'(32);
    end else if (cfg_wr) begin
      case (reg_idx)
        stm_pkg::REG_SCROLL_MODE:     scroll_mode     <= pwdata[1:0];
        stm_pkg::REG_STEP_INTERVAL:   step_interval   <= pwdata[stm_pkg::CNT_W-1:0];
        stm_pkg::REG_HOLD_TICKS:      hold_ticks      <= pwdata[stm_pkg::CNT_W-1:0];
        stm_pkg::REG_REPEAT_ENABLE:   repeat_enable   <= pwdata[0];
        stm_pkg::REG_ALIGNMENT:       alignment       <= pwdata[1:0];
        stm_pkg::REG_VISIBLE_COLUMNS: visible_columns <= pwdata[stm_pkg::WID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      stm_pkg::REG_SCROLL_MODE:     prdata = stm_pkg::PDATA_W'(scroll_mode);
      stm_pkg::REG_STEP_INTERVAL:   prdata = stm_pkg::PDATA_W'(step_interval);
      stm_pkg::REG_HOLD_TICKS:      prdata = stm_pkg::PDATA_W'(hold_ticks);
      stm_pkg::REG_REPEAT_ENABLE:   prdata = stm_pkg::PDATA_W'(repeat_enable);
      stm_pkg::REG_ALIGNMENT:       prdata = stm_pkg::PDATA_W'(alignment);
      stm_pkg::REG_VISIBLE_COLUMNS: prdata = stm_pkg::PDATA_W'(visible_columns);
      default:                      prdata = '0;
    endcase
  end

  // settings bundle, width limited to the display
  stm_pkg::cfg_t cfg;
  assign cfg.mode     = scroll_mode;
  assign cfg.interval = step_interval;
  assign cfg.hold     = hold_ticks;
  assign cfg.rpt      = repeat_enable;
  assign cfg.align    = alignment;
  assign cfg.width    = stm_pkg::clamp_width(visible_columns);

  logic                       accept, frame_idle, start;
  logic                       we, re;
  logic [stm_pkg::ADDR_W-1:0] waddr, raddr;
  logic [stm_pkg::CHAR_W-1:0] wdata, rdata;
  stm_pkg::scroll_t           st;

  // input is taken only while no frame is in flight
  assign in_ready = frame_idle;
  assign accept   = in_valid && in_ready;
  assign start    = accept && (operation == stm_pkg::OP_TICK);

  stm_ram #(
    .WIDTH (stm_pkg::CHAR_W),
    .DEPTH (stm_pkg::TEXT_DEPTH)
  ) u_text (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  stm_scroll u_scroll (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .operation  (operation),
    .char_code  (char_code),
    .first_char (first_char),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .st         (st)
  );

  // tick state is updated at the accept edge; the frame reads it afterwards
  stm_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cfg         (cfg),
    .st          (st),
    .re          (re),
    .raddr       (raddr),
    .rdata       (rdata),
    .idle        (frame_idle),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .column      (column),
    .glyph       (glyph),
    .last_column (last_column)
  );

endmodule
